FILE: hw/rtl/uudlc_pkg.sv
package uudlc_pkg;

  // result kinds
  localparam logic [1:0] KIND_DATA    = 2'd0;
  localparam logic [1:0] KIND_STATUS  = 2'd1;
  localparam logic [1:0] KIND_SUMMARY = 2'd2;

  // line check results
  localparam logic [1:0] CHK_NONE = 2'd0;
  localparam logic [1:0] CHK_GOOD = 2'd1;
  localparam logic [1:0] CHK_BAD  = 2'd2;

  localparam logic [15:0] SUM_ZERO = 16'h0000;
  localparam logic [31:0] CNT_MAX  = 32'hffff_ffff;

  typedef struct packed {
    logic [7:0] char_code;
    logic       line_end;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  data_byte;
    logic [1:0]  line_status;
    logic [31:0] line_number;
    logic [31:0] bad_range_start;
    logic [15:0] running_sum;
    logic [31:0] byte_total;
    logic        last;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic       take;       // accept one character
    logic       feed_zero;  // pad the open group with a zero code
    logic       step;       // advance past one byte of the held group
    logic       emit_byte;  // present that byte as a data result
    logic       finish;     // present status or summary, close the line
    logic [1:0] idx;        // byte slot within the held group
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic grp_full;  // the offered character completes a group
    logic in_end;    // the offered character ends the line
    logic end_held;  // the accepted character ended the line
    logic live;      // bytes still owed on this line
    logic fill_full; // three codes wait in the group
    logic out_free;  // output register can take a result
  } stat_t;

  // character decode: printable range maps to (c - 32) mod 64, the rest to zero;
  // subtracting 32 in six bits only flips bit 5
  function automatic logic [5:0] dec6(input logic [7:0] c);
    return (!c[7] && (c[6:5] != 2'b00)) ? {~c[5], c[4:0]} : 6'd0;
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return (c == 8'd0) || (c == 8'd32) || ((c >= 8'd9) && (c <= 8'd13));
  endfunction

  // three pending codes plus the fourth give bytes {b0, b1, b2}
  function automatic logic [23:0] make_bytes(input logic [17:0] g, input logic [5:0] d);
    return {g[17:12], g[11:10], g[9:6], g[5:2], g[1:0], d};
  endfunction

  function automatic logic [5:0] bytes_sum6(input logic [23:0] b);
    return 6'(b[21:16] + b[13:8] + b[5:0]);
  endfunction

endpackage

FILE: hw/rtl/uudlc_datapath.sv
module uudlc_datapath #(
  parameter int LINE_CHARS = 80
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  uudlc_pkg::in_item_t  in_data,
  input  logic                 cfg_valid,
  input  logic                 cfg_data,
  input  logic                 out_ready,
  output logic                 out_valid,
  output uudlc_pkg::out_item_t out_data,
  input  uudlc_pkg::cmd_t      cmd,
  output uudlc_pkg::stat_t     st
);

  localparam int PW = $clog2(LINE_CHARS + 1);

  logic [PW-1:0] pos_r, pos_nxt;
  logic [5:0]    len_r, len_nxt;
  logic [17:0]   grp_r, grp_nxt;
  logic [1:0]    fill_r, fill_nxt;
  logic [6:0]    done_r, done_nxt;
  logic [5:0]    bsum_r, bsum_nxt;
  logic [5:0]    csum_r, csum_nxt;
  logic [1:0]    chk_r, chk_nxt;
  logic          chk_seen_r, chk_seen_nxt;
  logic [15:0]   sum_r, sum_nxt;
  logic [31:0]   bcnt_r, bcnt_nxt;
  logic [31:0]   lcnt_r, lcnt_nxt;
  logic [31:0]   pend_r, pend_nxt;
  logic          end_r, end_nxt;
  logic [23:0]   bytes_r, bytes_nxt;
  logic          en_r, en_nxt;
  logic          ovld_r, ovld_nxt;
  uudlc_pkg::out_item_t out_r, out_nxt;

  logic [5:0]  d_in;
  logic        in_body;
  logic        feed_ok;
  logic [7:0]  cur_byte;
  logic [15:0] sum_upd;
  logic [31:0] bcnt_upd;
  logic [31:0] start_v;

  assign d_in    = uudlc_pkg::dec6(in_data.char_code);
  assign in_body = (pos_r != '0) && (pos_r < PW'(LINE_CHARS - 1)) && (len_r != 6'd0);
  assign feed_ok = in_body && (done_r < {1'b0, len_r});

  assign st.grp_full  = feed_ok && (fill_r == 2'd3);
  assign st.in_end    = in_data.line_end;
  assign st.end_held  = end_r;
  assign st.live      = done_r < {1'b0, len_r};
  assign st.fill_full = fill_r == 2'd3;
  assign st.out_free  = !ovld_r || out_ready;

  always_comb begin
    case (cmd.idx)
      2'd0:    cur_byte = bytes_r[23:16];
      2'd1:    cur_byte = bytes_r[15:8];
      default: cur_byte = bytes_r[7:0];
    endcase
  end

  // rotate right by one, then add the byte
  assign sum_upd  = {sum_r[0], sum_r[15:1]} + {8'd0, cur_byte};
  assign bcnt_upd = (bcnt_r == uudlc_pkg::CNT_MAX) ? bcnt_r : bcnt_r + 32'd1;

  always_comb begin
    pos_nxt      = pos_r;
    len_nxt      = len_r;
    grp_nxt      = grp_r;
    fill_nxt     = fill_r;
    done_nxt     = done_r;
    bsum_nxt     = bsum_r;
    csum_nxt     = csum_r;
    chk_nxt      = chk_r;
    chk_seen_nxt = chk_seen_r;
    sum_nxt      = sum_r;
    bcnt_nxt     = bcnt_r;
    lcnt_nxt     = lcnt_r;
    pend_nxt     = pend_r;
    end_nxt      = end_r;
    bytes_nxt    = bytes_r;
    en_nxt       = cfg_valid ? cfg_data : en_r;
    out_nxt      = out_r;
    ovld_nxt     = out_ready ? 1'b0 : ovld_r;
    start_v      = 32'd0;

    if (cmd.take) begin
      end_nxt = in_data.line_end;
      if (pos_r == '0) begin
        len_nxt = d_in;
        if (d_in != 6'd0) begin
          lcnt_nxt = lcnt_r + 32'd1;
        end
      end else if (feed_ok) begin
        csum_nxt = 6'(csum_r + in_data.char_code[5:0]);
        if (fill_r == 2'd3) begin
          bytes_nxt = uudlc_pkg::make_bytes(grp_r, d_in);
          bsum_nxt  = 6'(bsum_r + uudlc_pkg::bytes_sum6(bytes_nxt));
          grp_nxt   = '0;
          fill_nxt  = 2'd0;
        end else begin
          grp_nxt  = {grp_r[11:0], d_in};
          fill_nxt = fill_r + 2'd1;
        end
      end else if (in_body && !chk_seen_r) begin
        chk_seen_nxt = 1'b1;
        if (uudlc_pkg::is_blank(in_data.char_code) || !en_r) begin
          chk_nxt = uudlc_pkg::CHK_NONE;
        end else if ((bsum_r == d_in) || (csum_r == d_in)) begin
          chk_nxt = uudlc_pkg::CHK_GOOD;
        end else begin
          chk_nxt = uudlc_pkg::CHK_BAD;
        end
      end
      if (pos_r < PW'(LINE_CHARS)) begin
        pos_nxt = pos_r + PW'(1);
      end
    end

    if (cmd.feed_zero) begin
      if (fill_r == 2'd3) begin
        bytes_nxt = uudlc_pkg::make_bytes(grp_r, 6'd0);
        bsum_nxt  = 6'(bsum_r + uudlc_pkg::bytes_sum6(bytes_nxt));
        grp_nxt   = '0;
        fill_nxt  = 2'd0;
      end else begin
        grp_nxt  = {grp_r[11:0], 6'd0};
        fill_nxt = fill_r + 2'd1;
      end
    end

    if (cmd.step) begin
      done_nxt = done_r + 7'd1;
    end

    if (cmd.emit_byte) begin
      sum_nxt                 = sum_upd;
      bcnt_nxt                = bcnt_upd;
      ovld_nxt                = 1'b1;
      out_nxt.kind            = uudlc_pkg::KIND_DATA;
      out_nxt.data_byte       = cur_byte;
      out_nxt.line_status     = uudlc_pkg::CHK_NONE;
      out_nxt.line_number     = lcnt_r;
      out_nxt.bad_range_start = 32'd0;
      out_nxt.running_sum     = sum_upd;
      out_nxt.byte_total      = bcnt_upd;
      out_nxt.last            = !end_r &&
                                ((cmd.idx == 2'd2) || ((done_r + 7'd1) == {1'b0, len_r}));
    end

    if (cmd.finish) begin
      ovld_nxt                = 1'b1;
      out_nxt.data_byte       = 8'd0;
      out_nxt.line_number     = lcnt_r;
      out_nxt.running_sum     = sum_r;
      out_nxt.byte_total      = bcnt_r;
      out_nxt.last            = 1'b1;
      if (len_r == 6'd0) begin
        out_nxt.kind            = uudlc_pkg::KIND_SUMMARY;
        out_nxt.line_status     = uudlc_pkg::CHK_NONE;
        out_nxt.bad_range_start = pend_r;
        sum_nxt  = uudlc_pkg::SUM_ZERO;
        bcnt_nxt = 32'd0;
        lcnt_nxt = 32'd0;
        pend_nxt = 32'd0;
      end else begin
        if (chk_r == uudlc_pkg::CHK_BAD) begin
          if (pend_r == 32'd0) begin
            pend_nxt = lcnt_r;
          end
        end else if ((chk_r == uudlc_pkg::CHK_GOOD) && (pend_r != 32'd0)) begin
          start_v  = pend_r;
          pend_nxt = 32'd0;
        end
        out_nxt.kind            = uudlc_pkg::KIND_STATUS;
        out_nxt.line_status     = chk_r;
        out_nxt.bad_range_start = start_v;
      end
      pos_nxt      = '0;
      len_nxt      = 6'd0;
      grp_nxt      = '0;
      fill_nxt     = 2'd0;
      done_nxt     = 7'd0;
      bsum_nxt     = 6'd0;
      csum_nxt     = 6'd0;
      chk_nxt      = uudlc_pkg::CHK_NONE;
      chk_seen_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r      <= '0;
      len_r      <= 6'd0;
      grp_r      <= '0;
      fill_r     <= 2'd0;
      done_r     <= 7'd0;
      bsum_r     <= 6'd0;
      csum_r     <= 6'd0;
      chk_r      <= uudlc_pkg::CHK_NONE;
      chk_seen_r <= 1'b0;
      sum_r      <= uudlc_pkg::SUM_ZERO;
      bcnt_r     <= 32'd0;
      lcnt_r     <= 32'd0;
      pend_r     <= 32'd0;
      end_r      <= 1'b0;
      en_r       <= 1'b1;
      ovld_r     <= 1'b0;
    end else begin
      pos_r      <= pos_nxt;
      len_r      <= len_nxt;
      grp_r      <= grp_nxt;
      fill_r     <= fill_nxt;
      done_r     <= done_nxt;
      bsum_r     <= bsum_nxt;
      csum_r     <= csum_nxt;
      chk_r      <= chk_nxt;
      chk_seen_r <= chk_seen_nxt;
      sum_r      <= sum_nxt;
      bcnt_r     <= bcnt_nxt;
      lcnt_r     <= lcnt_nxt;
      pend_r     <= pend_nxt;
      end_r      <= end_nxt;
      en_r       <= en_nxt;
      ovld_r     <= ovld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bytes_r <= bytes_nxt;
    out_r   <= out_nxt;
  end

  assign out_valid = ovld_r;
  assign out_data  = out_r;

  // a line never owes more than 63 bytes, padded up to a whole group
  a_done_bound: assert property (@(posedge clk) disable iff (!rst_n)
    done_r <= 7'd63)
    else $error("byte slot count past line limit");

endmodule

FILE: hw/rtl/uudlc_ctrl.sv
module uudlc_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  uudlc_pkg::stat_t st,
  output uudlc_pkg::cmd_t  cmd
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_GROUP  = 2'd1;
  localparam logic [1:0] ST_FLUSH  = 2'd2;
  localparam logic [1:0] ST_FINISH = 2'd3;

  logic [1:0] state_r, state_nxt;
  logic [1:0] idx_r, idx_nxt;
  logic       take;

  assign in_ready = (state_r == ST_IDLE);
  assign take     = in_valid && in_ready;

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    cmd           = '0;
    cmd.idx       = idx_r;
    case (state_r)
      ST_IDLE: begin
        cmd.take = take;
        if (take) begin
          idx_nxt = 2'd0;
          if (st.grp_full) begin
            state_nxt = ST_GROUP;
          end else if (st.in_end) begin
            state_nxt = ST_FLUSH;
          end
        end
      end
      ST_GROUP: begin
        // hold on a live byte until the output register frees up
        if (!st.live || st.out_free) begin
          cmd.step      = 1'b1;
          cmd.emit_byte = st.live;
          idx_nxt       = idx_r + 2'd1;
          if (idx_r == 2'd2) begin
            state_nxt = st.end_held ? ST_FLUSH : ST_IDLE;
          end
        end
      end
      ST_FLUSH: begin
        if (st.live) begin
          cmd.feed_zero = 1'b1;
          if (st.fill_full) begin
            idx_nxt   = 2'd0;
            state_nxt = ST_GROUP;
          end
        end else begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (st.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      idx_r   <= 2'd0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
    end
  end

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit_byte || cmd.finish) |-> st.out_free)
    else $error("result loaded over an untaken result");

  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_GROUP) |-> (idx_r != 2'd3))
    else $error("byte slot out of group");

  a_plain_char: assert property (@(posedge clk) disable iff (!rst_n)
    (take && !st.grp_full && !st.in_end) |=> (state_r == ST_IDLE))
    else $error("plain character did not return to idle");

endmodule

FILE: hw/rtl/uudecode_line_checker.sv
// Uudecode line checker: takes one character transaction per cycle on the in_ channel
// while the sequencer is idle, and returns decoded bytes, a status per line and a
// summary on a zero-length line on the out_ channel. A character that neither completes
// a four-character group nor ends the line returns the sequencer straight to idle. A
// character that completes a group is taken, then each byte slot is emitted in turn,
// since the single output register carries one result per cycle while out_ready allows.
// At line end the missing codes of each owed group are padded in at one per cycle and
// its byte slots emitted, then the sequencer finds nothing more owed and loads the status or summary.
// Any cycle with a result pending also waits on out_ready. The check_enable register
// resets to 1 and is written through the cfg_ channel, taken at once.
module uudecode_line_checker #(
  parameter int LINE_CHARS = 80
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // character transactions
  input  logic                 in_valid,
  output logic                 in_ready,
  input  uudlc_pkg::in_item_t  in_data,
  // result transactions
  output logic                 out_valid,
  input  logic                 out_ready,
  output uudlc_pkg::out_item_t out_data,
  // check_enable write
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic                 cfg_data
);

  uudlc_pkg::cmd_t  cmd;
  uudlc_pkg::stat_t st;

  // configuration register is a plain flop: always accept the write
  assign cfg_ready = 1'b1;

  // sequencer: take, emit byte slots, pad, close the line
  uudlc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  // decode, checksums, BSD sum, counters, bad-run tracking, output register
  uudlc_datapath #(
    .LINE_CHARS (LINE_CHARS)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cmd       (cmd),
    .st        (st)
  );

endmodule
